// ===== rtl/endless_pot_quadrature_decoder_core_defines.svh =====
// Assertion macros for the endless pot decoder checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef ENDLESS_POT_QUADRATURE_DECODER_CORE_DEFINES_SVH
`define ENDLESS_POT_QUADRATURE_DECODER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define EPQD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define EPQD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/epqd_pkg.sv =====
// Constants and widths for the endless pot dual-taper decoder.
// No dependencies.
package epqd_pkg;

	localparam int TAPER_W = 8;
	localparam int POS_W   = 10;
	localparam int WGT_W   = 7;
	localparam int PROD_W  = 16;
	localparam int ACC_W   = 16;
	localparam int ANGLE_W = 10;

	localparam logic [TAPER_W-1:0] TAPER_MID     = 8'd130;
	localparam logic [TAPER_W-1:0] WEIGHT_OFFSET = 8'd18;
	localparam logic [WGT_W-1:0]   WEIGHT_FULL   = 7'd100;

	// taper B position offsets: low branch adds 7 + 412, high branch 268 + 137
	localparam logic [POS_W-1:0] POS_B_LOW_OFS  = 10'd419;
	localparam logic [POS_W-1:0] POS_B_HIGH_OFS = 10'd405;
	localparam logic [POS_W-1:0] FULL_TURN      = 10'd550;
	// taper A position offsets: 7, or 268 + 275
	localparam logic [POS_W-1:0] POS_A_HIGH_OFS = 10'd7;
	localparam logic [POS_W-1:0] POS_A_LOW_OFS  = 10'd543;

	// acc * 10 / 550 == acc / 55 ; floor(acc * RECIP >> RECIP_SH) is exact for acc <= 54900
	localparam int RECIP_W  = 17;
	localparam int RECIP_SH = 22;
	localparam logic [RECIP_W-1:0] RECIP = 17'd76261;
	localparam int MUL_W = ACC_W + RECIP_W;
	localparam int QUO_W = MUL_W - RECIP_SH;

	localparam logic [QUO_W-1:0] ANGLE_SPAN = 11'd1000;

endpackage

// ===== rtl/endless_pot_quadrature_decoder_core.sv =====
// Top level of the endless pot dual-taper decoder: five-stage pipeline.
// Depends on epqd_pkg.
//
// Each transaction carries one pair of taper readings and yields one angle in 0..999.
// The pipeline takes one transaction per clock while the output is not stalled. Each
// angle passes through the stage registers s1 to s5 in turn before it reaches the
// output. The five stages are: weights and branch positions, two 10x7 multiplies,
// their sum, a 16x17 reciprocal multiply for the division by 55, and the shift and
// wrap into the output register. Each stage holds its own valid bit and advances when
// the stage after it is empty or moving, so a stalled output fills the bubbles first.
module endless_pot_quadrature_decoder_core
	import epqd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               taper_valid,
	output logic               taper_ready,
	input  logic [TAPER_W-1:0] taper_a,
	input  logic [TAPER_W-1:0] taper_b,
	output logic               angle_valid,
	input  logic               angle_ready,
	output logic [ANGLE_W-1:0] angle
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	logic [POS_W-1:0] pa_s1, pb_s1;
	logic [WGT_W-1:0] wa_s1, wb_s1;
	logic [PROD_W-1:0] pwa_s2, pwb_s2;
	logic [ACC_W-1:0] acc_s3;
	logic [MUL_W-1:0] mul_s4;
	logic [ANGLE_W-1:0] angle_s5;

	logic               a_low, b_high;
	logic [TAPER_W-1:0] mid_dist;
	logic [TAPER_W-1:0] wb_raw;
	logic [WGT_W-1:0]   wb_c, wa_c;
	logic [POS_W-1:0]   pb_sum, pb_c, pa_c;
	logic [QUO_W-1:0]   quo;
	logic [QUO_W-1:0]   quo_w;

	assign en5 = !v_s5 || angle_ready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign taper_ready = en1;
	assign angle_valid = v_s5;
	assign angle = angle_s5;

	always_comb begin
		a_low    = taper_a < TAPER_MID;
		b_high   = taper_b > TAPER_MID;
		mid_dist = a_low ? (TAPER_MID - taper_a) : (taper_a - TAPER_MID);
		wb_raw   = (mid_dist <= WEIGHT_OFFSET) ? '0 : (mid_dist - WEIGHT_OFFSET);
		wb_c     = (wb_raw > TAPER_W'(WEIGHT_FULL)) ? WEIGHT_FULL : wb_raw[WGT_W-1:0];
		wa_c     = WEIGHT_FULL - wb_c;
		pb_sum   = POS_W'(taper_b) + POS_B_LOW_OFS;
		if (a_low) begin
			pb_c = (pb_sum >= FULL_TURN) ? (pb_sum - FULL_TURN) : pb_sum;
		end else begin
			pb_c = POS_B_HIGH_OFS - POS_W'(taper_b);
		end
		pa_c = b_high ? (POS_W'(taper_a) + POS_A_HIGH_OFS)
			: (POS_A_LOW_OFS - POS_W'(taper_a));
	end

	always_comb begin
		quo   = mul_s4[MUL_W-1:RECIP_SH];
		quo_w = (quo >= ANGLE_SPAN) ? (quo - ANGLE_SPAN) : quo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= taper_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && taper_valid) begin
			pa_s1 <= pa_c;
			pb_s1 <= pb_c;
			wa_s1 <= wa_c;
			wb_s1 <= wb_c;
		end
		if (en2 && v_s1) begin
			pwa_s2 <= PROD_W'(pa_s1 * wa_s1);
			pwb_s2 <= PROD_W'(pb_s1 * wb_s1);
		end
		if (en3 && v_s2) begin
			acc_s3 <= ACC_W'(pwa_s2 + pwb_s2);
		end
		if (en4 && v_s3) begin
			mul_s4 <= MUL_W'(acc_s3 * RECIP);
		end
		if (en5 && v_s4) begin
			angle_s5 <= quo_w[ANGLE_W-1:0];
		end
	end

endmodule

// ===== rtl/epqd_checker.sv =====
// Port-level checker for the endless pot decoder, bound to the top level.
// Depends on epqd_pkg and endless_pot_quadrature_decoder_core_defines.svh.
`include "endless_pot_quadrature_decoder_core_defines.svh"

module epqd_checker
	import epqd_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               taper_valid,
	input logic               taper_ready,
	input logic [TAPER_W-1:0] taper_a,
	input logic [TAPER_W-1:0] taper_b,
	input logic               angle_valid,
	input logic               angle_ready,
	input logic [ANGLE_W-1:0] angle
);

	`EPQD_ASSERT_IMPL(a_angle_range, angle_valid, angle < ANGLE_W'(ANGLE_SPAN), "angle out of range")
	`EPQD_ASSERT_IMPL(a_ready_low_full, !taper_ready, angle_valid && !angle_ready, "input stalled while output free")
	`EPQD_ASSERT_NEXT(a_out_hold_valid, angle_valid && !angle_ready, angle_valid, "output transaction dropped")
	`EPQD_ASSERT_NEXT(a_out_hold_data, angle_valid && !angle_ready, $stable(angle), "stalled angle changed")
	`EPQD_ASSERT_NEXT(a_in_hold, taper_valid && !taper_ready, taper_valid && $stable(taper_a) && $stable(taper_b), "waiting input transaction changed")

endmodule

bind endless_pot_quadrature_decoder_core epqd_checker u_epqd_checker (.*);
